@@ rtl/core/lir_pkg.sv @@
package lir_pkg;

	// Fixed widths of the ports.
	localparam int SAMPLE_W      = 16;
	localparam int CHAN_OUT_W    = 3;
	localparam int CH_COUNT_W    = 4;
	localparam int RATE_STEP_W   = 20;
	localparam int CFG_IDX_W     = 1;
	localparam int CFG_DATA_W    = 20;
	localparam int RESULT_CNT_W  = 4;

	// Defaults of the top-level parameters.
	localparam int MAX_CHANNELS_DEF    = 8;
	localparam int PHASE_FRAC_BITS_DEF = 16;

	// At most this many results follow from one input beat.
	localparam logic [RESULT_CNT_W-1:0] MAX_RESULTS = RESULT_CNT_W'(9);

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_RATE_STEP     = 1'b1;

	// Reset values of the configuration registers.
	localparam logic [CH_COUNT_W-1:0]  CH_COUNT_RESET  = CH_COUNT_W'(1);
	localparam logic [RATE_STEP_W-1:0] RATE_STEP_RESET = RATE_STEP_W'(65536);

	// Configuration as seen by the sequencer.
	typedef struct packed {
		logic [CH_COUNT_W-1:0]  channel_count;
		logic [RATE_STEP_W-1:0] rate_step;
	} cfg_t;

endpackage

@@ rtl/core/lir_ram.sv @@
module lir_ram
	import lir_pkg::*;
#(
	parameter int WIDTH = SAMPLE_W,
	parameter int DEPTH = MAX_CHANNELS_DEF
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/core/lir_engine.sv @@
module lir_engine
	import lir_pkg::*;
#(
	parameter int MAX_CHANNELS    = MAX_CHANNELS_DEF,
	parameter int PHASE_FRAC_BITS = PHASE_FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cfg_t                        cfg,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic signed [SAMPLE_W-1:0]  sample_in,
	input  logic                        final_frame,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [SAMPLE_W-1:0]  sample_out,
	output logic [CHAN_OUT_W-1:0]       channel_out,
	output logic                        last_of_run,
	output logic                        end_of_block,
	output logic                        ram_re,
	output logic [(MAX_CHANNELS > 1 ? $clog2(MAX_CHANNELS) : 1)-1:0] ram_raddr,
	output logic                        ram_we,
	output logic [(MAX_CHANNELS > 1 ? $clog2(MAX_CHANNELS) : 1)-1:0] ram_waddr,
	output logic [SAMPLE_W-1:0]         ram_wdata,
	input  logic [SAMPLE_W-1:0]         ram_rdata
);

	localparam int CH_W  = MAX_CHANNELS > 1 ? $clog2(MAX_CHANNELS) : 1;
	localparam int CNT_W = CH_COUNT_W + 1;
	localparam int FB    = PHASE_FRAC_BITS;
	localparam int PH_W  = ((FB + 2 > RATE_STEP_W) ? FB + 2 : RATE_STEP_W) + 1;
	localparam int PR_W  = FB + SAMPLE_W + 2;

	localparam logic [CNT_W-1:0] MAX_CH_C = CNT_W'(MAX_CHANNELS);
	localparam logic [PH_W-1:0]  ONE      = PH_W'(1) << FB;
	localparam logic [PH_W-1:0]  TWO      = ONE << 1;
	localparam logic [PH_W-1:0]  STEP_MIN = ONE >> 3;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic state_q;

	// Frame state that persists between beats.
	logic [CH_W-1:0]         chan_ctr_q;
	logic [PH_W-1:0]         phase_q;
	logic                    first_seen_q;
	logic [MAX_CHANNELS-1:0] prev_valid_q;

	// Context of the beat in progress.
	logic signed [SAMPLE_W-1:0] cur_q;
	logic                       final_q;
	logic                       first_q;
	logic                       last_ch_q;
	logic [CH_W-1:0]            ch_q;
	logic [PH_W-1:0]            ph_q;
	logic [PH_W-1:0]            step_q;
	logic [RESULT_CNT_W-1:0]    n_q;

	// Output register.
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] sample_out_q;
	logic [CHAN_OUT_W-1:0]      channel_out_q;
	logic                       last_of_run_q;
	logic                       end_of_block_q;

	logic [CNT_W-1:0] cnt_ext, cnt_eff, last_idx, ctr_ext, ch_sel_ext;
	logic [CH_W-1:0]  ch_sel;
	logic             last_ch_sel;
	logic [PH_W-1:0]  step_ext, step_eff;
	logic             accept;

	// Clamp the channel count, the counter and the rate step into the valid range.
	always_comb begin
		cnt_ext = CNT_W'(cfg.channel_count);
		if (cnt_ext == '0) begin
			cnt_eff = CNT_W'(1);
		end else if (cnt_ext > MAX_CH_C) begin
			cnt_eff = MAX_CH_C;
		end else begin
			cnt_eff = cnt_ext;
		end
		last_idx   = cnt_eff - CNT_W'(1);
		ctr_ext    = CNT_W'(chan_ctr_q);
		ch_sel_ext = (ctr_ext >= cnt_eff) ? last_idx : ctr_ext;
		ch_sel     = ch_sel_ext[CH_W-1:0];
		last_ch_sel = (ch_sel_ext == last_idx);
		step_ext   = PH_W'(cfg.rate_step);
		step_eff   = (step_ext < STEP_MIN) ? STEP_MIN : step_ext;
	end

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	// Previous sample of this channel; an entry never written reads as zero.
	logic signed [SAMPLE_W-1:0] prev_w;
	logic signed [SAMPLE_W:0]   diff_w;
	logic [FB-1:0]              frac_w;
	logic signed [PR_W-1:0]     prod_w, total_w, quot_w;
	logic                       round_w;
	logic signed [SAMPLE_W-1:0] interp_w;

	// Interpolation: prev + frac*(cur-prev), truncated toward zero.
	always_comb begin
		prev_w   = prev_valid_q[ch_q] ? signed'(ram_rdata) : '0;
		diff_w   = (SAMPLE_W + 1)'(cur_q) - (SAMPLE_W + 1)'(prev_w);
		frac_w   = ph_q[FB-1:0];
		prod_w   = $signed({1'b0, frac_w}) * diff_w;
		total_w  = (PR_W'(prev_w) <<< FB) + prod_w;
		quot_w   = total_w >>> FB;
		round_w  = total_w[PR_W-1] && (|total_w[FB-1:0]);
		interp_w = quot_w[SAMPLE_W-1:0] + SAMPLE_W'(round_w);
	end

	logic [PH_W-1:0]         lim_w, ph_next, ph_end;
	logic [RESULT_CNT_W-1:0] n_next;
	logic                    do_interp, do_hold, emit, more, out_free, advance, finish;

	// Decide whether this cycle emits a result and whether the run ends.
	always_comb begin
		lim_w     = first_q ? TWO : ONE;
		do_interp = first_q && (ph_q < ONE);
		do_hold   = final_q && (ph_q < lim_w);
		emit      = (n_q < MAX_RESULTS) && (do_interp || do_hold);
		ph_next   = ph_q + step_q;
		n_next    = n_q + RESULT_CNT_W'(1);
		more      = (n_next < MAX_RESULTS) &&
			((first_q && (ph_next < ONE)) || (final_q && (ph_next < lim_w)));
		out_free  = !out_valid_q || !out_stall;
		advance   = (state_q == ST_RUN) && emit && out_free;
		finish    = (state_q == ST_RUN) && (!emit || (advance && !more));
		ph_end    = emit ? ph_next : ph_q;
	end

	// Memory access: read at accept, write the current sample back at the end.
	assign ram_re    = accept;
	assign ram_raddr = ch_sel;
	assign ram_we    = finish;
	assign ram_waddr = ch_q;
	assign ram_wdata = cur_q;

	// Sequencer and frame state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			chan_ctr_q   <= '0;
			phase_q      <= '0;
			first_seen_q <= 1'b0;
			prev_valid_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q    <= ST_RUN;
						chan_ctr_q <= last_ch_sel ? '0 : ch_sel + CH_W'(1);
					end
				end
				ST_RUN: begin
					if (finish) begin
						state_q              <= ST_IDLE;
						prev_valid_q[ch_q]   <= 1'b1;
						if (last_ch_q) begin
							if (final_q) begin
								phase_q      <= '0;
								first_seen_q <= 1'b0;
							end else if (first_q) begin
								phase_q <= (ph_end >= ONE) ? ph_end - ONE : '0;
							end else begin
								first_seen_q <= 1'b1;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Context of the beat: loaded at accept, phase and count advance per result.
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q     <= sample_in;
			final_q   <= final_frame;
			first_q   <= first_seen_q;
			last_ch_q <= last_ch_sel;
			ch_q      <= ch_sel;
			ph_q      <= phase_q;
			step_q    <= step_eff;
			n_q       <= '0;
		end else if (advance) begin
			ph_q <= ph_next;
			n_q  <= n_next;
		end
	end

	// Output register: a result waits here while the next one is prepared.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			sample_out_q   <= do_interp ? interp_w : cur_q;
			channel_out_q  <= CHAN_OUT_W'(ch_q);
			last_of_run_q  <= !more;
			end_of_block_q <= !more && final_q && last_ch_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign sample_out   = sample_out_q;
	assign channel_out  = channel_out_q;
	assign last_of_run  = last_of_run_q;
	assign end_of_block = end_of_block_q;

endmodule

@@ rtl/core/linear_interp_resampler_unit.sv @@
// At acceptance a beat's context is registered and its channel's previous sample read
// from RAM; no new beat is taken until its run of 0 to 9 results has ended. Results
// leave one per cycle from the single output register while out_stall is low.
// Reset (arst_n, asynchronous): channel_count = 1, rate_step = 1.0, phase, counter and
// first-frame flag cleared, all stored previous samples read as zero until rewritten.
module linear_interp_resampler_unit
	import lir_pkg::*;
#(
	parameter int MAX_CHANNELS    = MAX_CHANNELS_DEF,
	parameter int PHASE_FRAC_BITS = PHASE_FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]       cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic signed [SAMPLE_W-1:0]  sample_in,
	input  logic                        final_frame,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [SAMPLE_W-1:0]  sample_out,
	output logic [CHAN_OUT_W-1:0]       channel_out,
	output logic                        last_of_run,
	output logic                        end_of_block
);

	localparam int CH_W = MAX_CHANNELS > 1 ? $clog2(MAX_CHANNELS) : 1;

	cfg_t cfg_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.channel_count <= CH_COUNT_RESET;
			cfg_q.rate_step     <= RATE_STEP_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CHANNEL_COUNT: cfg_q.channel_count <= cfg_data[CH_COUNT_W-1:0];
				REG_RATE_STEP:     cfg_q.rate_step     <= cfg_data[RATE_STEP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	logic                ram_re, ram_we;
	logic [CH_W-1:0]     ram_raddr, ram_waddr;
	logic [SAMPLE_W-1:0] ram_wdata, ram_rdata;

	// Previous sample of each channel.
	lir_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(MAX_CHANNELS)
	) u_prev_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	lir_engine #(
		.MAX_CHANNELS   (MAX_CHANNELS),
		.PHASE_FRAC_BITS(PHASE_FRAC_BITS)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.sample_in   (sample_in),
		.final_frame (final_frame),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.sample_out  (sample_out),
		.channel_out (channel_out),
		.last_of_run (last_of_run),
		.end_of_block(end_of_block),
		.ram_re      (ram_re),
		.ram_raddr   (ram_raddr),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.ram_wdata   (ram_wdata),
		.ram_rdata   (ram_rdata)
	);

endmodule

@@ sim/linear_interp_resampler_checker.sv @@
module linear_interp_resampler_checker
	import lir_pkg::*;
#(
	parameter int MAX_CHANNELS    = MAX_CHANNELS_DEF,
	parameter int PHASE_FRAC_BITS = PHASE_FRAC_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	input  logic                   in_stall,
	input  logic [SAMPLE_W-1:0]    sample_in,
	input  logic                   final_frame,
	input  logic                   out_valid,
	input  logic                   out_stall,
	input  logic [SAMPLE_W-1:0]    sample_out,
	input  logic [CHAN_OUT_W-1:0]  channel_out,
	input  logic                   last_of_run,
	input  logic                   end_of_block,
	output int                     mismatches,
	output int                     outstanding
);

	localparam int REPORT_LIMIT = 10;
	localparam int RUN_MAX = int'(MAX_RESULTS);
	localparam logic [31:0] UNIT = 32'd1 << PHASE_FRAC_BITS;
	localparam int PHASE_W = RATE_STEP_W + 1;

	typedef struct packed {
		logic [SAMPLE_W-1:0]   sample;
		logic [CHAN_OUT_W-1:0] channel;
		logic                  run_end;
		logic                  block_end;
	} out_beat_t;

	// Output beats predicted but not yet seen, oldest first.
	out_beat_t due_outputs[$];

	// Shadow copy of the block's registers and state.
	logic [CH_COUNT_W-1:0]  chan_setting;
	logic [RATE_STEP_W-1:0] step_setting;
	logic [SAMPLE_W-1:0]    prev_frame [MAX_CHANNELS];
	logic [PHASE_W-1:0]     phase;
	logic [CHAN_OUT_W-1:0]  chan_idx;
	logic                   frame_seen;

	int        fail_total;
	out_beat_t got;
	out_beat_t want;

	// Point between two samples at a fractional position, truncated toward zero.
	function automatic logic [SAMPLE_W-1:0] lerp_sample(input logic [SAMPLE_W-1:0] prev,
			input logic [SAMPLE_W-1:0] cur, input logic [31:0] frac);
		longint span;
		longint acc;
		span = longint'($signed(cur)) - longint'($signed(prev));
		acc = longint'($signed(prev)) * longint'(UNIT) + longint'(frac) * span;
		return SAMPLE_W'(acc / longint'(UNIT));
	endfunction

	// Work out the output beats caused by one input beat and advance the state.
	task automatic resample_beat(input logic [SAMPLE_W-1:0] cur, input logic fin);
		out_beat_t   run_beats [RUN_MAX];
		logic [31:0] step;
		logic [31:0] ph;
		logic [31:0] tail_end;
		int unsigned cnt;
		int unsigned ch;
		bit          last_ch;
		int          n;
		n = 0;
		step = (32'(step_setting) < (UNIT >> 3)) ? (UNIT >> 3) : 32'(step_setting);
		cnt = chan_setting;
		if (cnt < 1)
			cnt = 1;
		if (cnt > MAX_CHANNELS)
			cnt = MAX_CHANNELS;
		ch = chan_idx;
		if (ch >= cnt)
			ch = cnt - 1;
		last_ch = (ch == cnt - 1);
		ph = 32'(phase);

		// Positions between the previous frame and this one.
		if (frame_seen) begin
			while (ph < UNIT && n < RUN_MAX) begin
				run_beats[n] = '{lerp_sample(prev_frame[ch], cur, ph), CHAN_OUT_W'(ch),
					1'b0, 1'b0};
				n++;
				ph += step;
			end
		end
		// On a final frame, the tail holds the last sample.
		if (fin) begin
			tail_end = frame_seen ? 2 * UNIT : UNIT;
			while (ph < tail_end && n < RUN_MAX) begin
				run_beats[n] = '{cur, CHAN_OUT_W'(ch), 1'b0, 1'b0};
				n++;
				ph += step;
			end
		end
		prev_frame[ch] = cur;

		if (n > 0) begin
			run_beats[n - 1].run_end = 1'b1;
			run_beats[n - 1].block_end = fin && last_ch;
		end
		for (int i = 0; i < n; i++)
			due_outputs.push_back(run_beats[i]);

		if (last_ch) begin
			chan_idx = '0;
			if (fin) begin
				phase = '0;
				frame_seen = 1'b0;
			end else if (frame_seen) begin
				phase = (ph >= UNIT) ? PHASE_W'(ph - UNIT) : '0;
			end else begin
				frame_seen = 1'b1;
			end
		end else begin
			chan_idx = CHAN_OUT_W'(ch + 1);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			due_outputs.delete();
			chan_setting = CH_COUNT_RESET;
			step_setting = RATE_STEP_RESET;
			for (int i = 0; i < MAX_CHANNELS; i++)
				prev_frame[i] = '0;
			phase = '0;
			chan_idx = '0;
			frame_seen = 1'b0;
			fail_total = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			// Compare an accepted output beat with the oldest prediction.
			if (out_valid && !out_stall) begin
				got = {sample_out, channel_out, last_of_run, end_of_block};
				if (due_outputs.size() == 0) begin
					if (fail_total < REPORT_LIMIT)
						$display("unexpected output beat: sample %0d channel %0d last %b end %b",
							$signed(got.sample), got.channel, got.run_end, got.block_end);
					fail_total++;
				end else begin
					want = due_outputs.pop_front();
					if (got !== want) begin
						if (fail_total < REPORT_LIMIT)
							$display({"output beat mismatch: expected sample %0d channel %0d ",
								"last %b end %b, got sample %0d channel %0d last %b end %b"},
								$signed(want.sample), want.channel, want.run_end,
								want.block_end, $signed(got.sample), got.channel,
								got.run_end, got.block_end);
						fail_total++;
					end
				end
			end

			if (cfg_we) begin
				case (cfg_index)
					REG_CHANNEL_COUNT: chan_setting = cfg_data[CH_COUNT_W-1:0];
					REG_RATE_STEP:     step_setting = cfg_data[RATE_STEP_W-1:0];
					default: ;
				endcase
			end

			if (in_valid && !in_stall)
				resample_beat(sample_in, final_frame);

			mismatches <= fail_total;
			outstanding <= due_outputs.size();
		end
	end

endmodule

@@ sim/linear_interp_resampler_unit_test.sv @@
module linear_interp_resampler_unit_test;
	import lir_pkg::*;

	localparam int CLK_PERIOD    = 4;
	localparam int RESET_CYCLES  = 7;
	localparam int IDLE_LIMIT    = 3000;
	localparam int SETTLE_CYCLES = 16;
	localparam int RANDOM_BEATS  = 140;

	localparam logic [RATE_STEP_W-1:0] STEP_UNITY = RATE_STEP_W'(65536);
	localparam logic [RATE_STEP_W-1:0] STEP_MIN   = RATE_STEP_W'(8192);
	localparam logic [RATE_STEP_W-1:0] STEP_MAX   = RATE_STEP_W'(786432);
	localparam logic [SAMPLE_W-1:0]    PEAK_POS   = 16'h7FFF;
	localparam logic [SAMPLE_W-1:0]    PEAK_NEG   = 16'h8000;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_SPARSE,
		STALL_DENSE,
		STALL_PERIODIC
	} stall_mode_e;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   in_valid;
	logic                   in_stall;
	logic [SAMPLE_W-1:0]    sample_in;
	logic                   final_frame;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [SAMPLE_W-1:0]    sample_out;
	logic [CHAN_OUT_W-1:0]  channel_out;
	logic                   last_of_run;
	logic                   end_of_block;

	int          mismatches;
	int          outstanding;
	int          idle_cycles = 0;
	int          burst_left;
	int          beats_sent;
	int          stall_left = 0;
	stall_mode_e stall_mode = STALL_NONE;

	always #(CLK_PERIOD / 2) clk = ~clk;

	linear_interp_resampler_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sample_in    (sample_in),
		.final_frame  (final_frame),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sample_out   (sample_out),
		.channel_out  (channel_out),
		.last_of_run  (last_of_run),
		.end_of_block (end_of_block)
	);

	linear_interp_resampler_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sample_in    (sample_in),
		.final_frame  (final_frame),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sample_out   (sample_out),
		.channel_out  (channel_out),
		.last_of_run  (last_of_run),
		.end_of_block (end_of_block),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	// Receiver stalls in modes that change when a random countdown runs out.
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= stall_mode_e'($urandom_range(0, 3));
			stall_left <= $urandom_range(20, 150);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			STALL_NONE:     out_stall <= 1'b0;
			STALL_SPARSE:   out_stall <= ($urandom_range(0, 3) == 0);
			STALL_DENSE:    out_stall <= ($urandom_range(0, 3) != 0);
			STALL_PERIODIC: out_stall <= stall_left[2];
			default:        out_stall <= 1'b0;
		endcase
	end

	// Watchdog: too long without any beat or register write ends the run.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Offer one input beat, inside a burst or after a random gap.
	task automatic send_beat(input logic [SAMPLE_W-1:0] value, input logic fin);
		int gap;
		bit took;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		in_valid <= 1'b1;
		sample_in <= value;
		final_frame <= fin;
		do begin
			@(negedge clk);
			took = !in_stall;
			@(posedge clk);
		end while (!took);
	endtask

	// Drop valid and wait until every predicted beat has left and the block settled.
	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write both registers while the block is idle.
	task automatic set_mode(input logic [CH_COUNT_W-1:0] chans,
			input logic [RATE_STEP_W-1:0] step);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= REG_CHANNEL_COUNT;
		cfg_data <= CFG_DATA_W'(chans);
		@(posedge clk);
		cfg_index <= REG_RATE_STEP;
		cfg_data <= CFG_DATA_W'(step);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin : stimulus
		logic [CH_COUNT_W-1:0]  chans;
		logic [RATE_STEP_W-1:0] step;
		logic [SAMPLE_W-1:0]    value;
		logic                   fin;
		int                     active_chans;
		int                     frames;
		int                     phase_end;

		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_CHANNEL_COUNT;
		cfg_data <= '0;
		in_valid <= 1'b0;
		sample_in <= '0;
		final_frame <= 1'b0;
		burst_left = 0;
		beats_sent = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: a block of one frame, then full-scale swings at unity rate.
		send_beat(PEAK_POS, 1'b1);
		send_beat(16'd8000, 1'b0);
		send_beat(PEAK_NEG, 1'b0);
		send_beat(PEAK_POS, 1'b1);

		// Slowest step on two channels: the final frame hits the result limit.
		set_mode(4'd2, STEP_MIN);
		send_beat(16'd100, 1'b0);
		send_beat(-16'sd100, 1'b0);
		send_beat(PEAK_POS, 1'b1);
		send_beat(PEAK_NEG, 1'b1);

		// Largest step: the phase runs past the tail and the block ends silently.
		set_mode(4'd1, STEP_MAX);
		send_beat(16'd5, 1'b0);
		send_beat(16'd6, 1'b0);
		send_beat(16'd7, 1'b0);
		send_beat(16'd8, 1'b1);

		// Zero channels acts as one, a tiny step acts as the minimum; rounding toward zero.
		set_mode(4'd0, RATE_STEP_W'(100));
		send_beat(16'hFFFF, 1'b0);
		send_beat(16'd1, 1'b1);

		// Channel count above the maximum, with mixed final flags in one frame.
		set_mode(4'd15, STEP_UNITY);
		for (int c = 0; c < MAX_CHANNELS_DEF; c++)
			send_beat(SAMPLE_W'(c * 4001 - 16000), (c % 2 == 0) && (c != MAX_CHANNELS_DEF - 1));

		// Channel count lowered in the middle of a frame.
		set_mode(4'd3, STEP_UNITY);
		send_beat(16'h1234, 1'b0);
		send_beat(16'hEDCB, 1'b0);
		set_mode(4'd1, STEP_UNITY);
		send_beat(16'h0F0F, 1'b1);

		// Random phases of well-formed blocks, with a share of flipped final flags.
		while (beats_sent < RANDOM_BEATS) begin
			chans = ($urandom_range(0, 7) == 0) ? CH_COUNT_W'($urandom_range(0, 15))
				: CH_COUNT_W'($urandom_range(1, MAX_CHANNELS_DEF));
			case ($urandom_range(0, 9))
				0:       step = STEP_MIN;
				1:       step = STEP_MAX;
				2:       step = RATE_STEP_W'($urandom_range(0, STEP_MIN - 1));
				3:       step = RATE_STEP_W'($urandom_range(STEP_MAX + 1, 20'hFFFFF));
				4:       step = STEP_UNITY;
				default: step = RATE_STEP_W'($urandom_range(STEP_MIN, STEP_MAX));
			endcase
			set_mode(chans, step);
			active_chans = (chans == 0) ? 1
				: ((chans > MAX_CHANNELS_DEF) ? MAX_CHANNELS_DEF : int'(chans));
			phase_end = beats_sent + 20 + $urandom_range(0, 20);
			while (beats_sent < phase_end) begin
				frames = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 5);
				for (int f = 0; f < frames; f++) begin
					for (int c = 0; c < active_chans; c++) begin
						fin = (f == frames - 1);
						if ($urandom_range(0, 11) == 0)
							fin = ~fin;
						case ($urandom_range(0, 7))
							0:       value = PEAK_POS;
							1:       value = PEAK_NEG;
							2:       value = SAMPLE_W'($signed($urandom_range(0, 6)) - 3);
							default: value = SAMPLE_W'($urandom);
						endcase
						send_beat(value, fin);
						beats_sent++;
					end
				end
			end
		end

		// Drain and give the verdict.
		wait_idle();
		@(negedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/lir_pkg.sv
rtl/core/lir_ram.sv
rtl/core/lir_engine.sv
rtl/core/linear_interp_resampler_unit.sv
sim/linear_interp_resampler_checker.sv
sim/linear_interp_resampler_unit_test.sv
